@@ src/event_mapping_match_table_assert.svh @@
// Assertion macros for the event mapping match table.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef EVENT_MAPPING_MATCH_TABLE_ASSERT_SVH
`define EVENT_MAPPING_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EMMT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define EMMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/emmt_pkg.sv @@
// Package for the event mapping match table: sizes, operation codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package emmt_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam int WORD_W = 32;
   localparam int KEY_W = 20;
   localparam int FID_W = 6;
   localparam int DATA_W = 6;

   // operation codes; the fourth code is ignored
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_EXEC = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic add;
      logic exec;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last_issue;
   } status_type;

endpackage

`default_nettype wire

@@ src/emmt_ctrl.sv @@
// Controller for the event mapping match table: sequences clear, add and
// the table walk of a lookup. Depends on emmt_pkg and the assertion header.
`default_nettype none

`include "event_mapping_match_table_assert.svh"

module emmt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_operation,
   input  wire emmt_pkg::status_type status,
   output emmt_pkg::cmd_type       cmd,
   output logic                    busy
);
   import emmt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_operation)
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_ADD: cmd.add = 1'b1;
                  OP_EXEC: begin
                     cmd.exec = 1'b1;
                     state_in = status.count_zero ? ST_FINISH : ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `EMMT_ASSERT_NEXT(a_walk_done_drains, clock, reset,
      state_ff == ST_WALK && status.last_issue, state_ff == ST_DRAIN,
      "walk did not move to drain after the last read")
   `EMMT_ASSERT_NEXT(a_drain_finishes, clock, reset,
      state_ff == ST_DRAIN, state_ff == ST_FINISH && cmd.finish,
      "drain did not move to finish")
   `EMMT_ASSERT_IMPL(a_walk_nonempty, clock, reset,
      state_ff == ST_WALK, !status.count_zero,
      "table walk with an empty table")

endmodule

`default_nettype wire

@@ src/emmt_datapath.sv @@
// Event mapping match table datapath: table memory, entry count, key
// compare, pending match, result regs; uses emmt_pkg, assertion header.
`default_nettype none

`include "event_mapping_match_table_assert.svh"

module emmt_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire emmt_pkg::cmd_type  cmd,
   input  wire logic [15:0]        req_loco_id,
   input  wire logic [1:0]         req_dot,
   input  wire logic [1:0]         req_direction,
   input  wire logic [31:0]        req_entry_word,
   output emmt_pkg::status_type    status,
   output logic                    rsp_strobe,
   output logic                    rsp_hit,
   output logic [5:0]              rsp_function_id,
   output logic [5:0]              rsp_function_data,
   output logic                    rsp_table_full,
   output logic                    rsp_last
);
   import emmt_pkg::*;

   logic [WORD_W-1:0] mem [MAX_ENTRIES];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic              rd_vld_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              pend_vld_ff, pend_vld_in;
   logic [FID_W-1:0]  pend_fid_ff, pend_fid_in;
   logic [DATA_W-1:0] pend_data_ff, pend_data_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [FID_W-1:0]  rsp_fid_ff, rsp_fid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              table_full;
   logic              match;

   assign table_full = (count_ff == CNT_W'(MAX_ENTRIES));
   assign match = rd_vld_ff && (rd_data_ff[WORD_W-1 -: KEY_W] == key_ff);

   assign status.count_zero = (count_ff == '0);
   assign status.last_issue = (CNT_W'(ptr_ff) == (count_ff - CNT_W'(1)));

   // table memory: append port, walk read port
   always_ff @(posedge clock) begin
      if (cmd.add && !table_full) begin
         mem[count_ff[IDX_W-1:0]] <= req_entry_word;
      end
      rd_data_ff <= mem[ptr_ff];
   end

   always_comb begin
      count_in = count_ff;
      key_in = key_ff;
      ptr_in = ptr_ff;
      pend_vld_in = pend_vld_ff;
      pend_fid_in = pend_fid_ff;
      pend_data_in = pend_data_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in = 1'b0;
      rsp_fid_in = '0;
      rsp_data_in = '0;
      rsp_full_in = 1'b0;
      rsp_last_in = 1'b0;

      if (cmd.clear) begin
         count_in = '0;
         rsp_valid_in = 1'b1;
         rsp_last_in = 1'b1;
      end
      if (cmd.add) begin
         if (table_full) begin
            rsp_full_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_last_in = 1'b1;
      end
      if (cmd.exec) begin
         key_in = {req_loco_id, req_dot, req_direction};
         ptr_in = '0;
         pend_vld_in = 1'b0;
      end
      if (cmd.issue) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end
      // a new match releases the one held before it, which cannot be last
      if (match) begin
         if (pend_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_hit_in = 1'b1;
            rsp_fid_in = pend_fid_ff;
            rsp_data_in = pend_data_ff;
         end
         pend_vld_in = 1'b1;
         pend_fid_in = rd_data_ff[FID_W+DATA_W-1:DATA_W];
         pend_data_in = rd_data_ff[DATA_W-1:0];
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_last_in = 1'b1;
         if (pend_vld_ff) begin
            rsp_hit_in = 1'b1;
            rsp_fid_in = pend_fid_ff;
            rsp_data_in = pend_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_vld_ff <= cmd.issue;
         pend_vld_ff <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      ptr_ff <= ptr_in;
      pend_fid_ff <= pend_fid_in;
      pend_data_ff <= pend_data_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_fid_ff <= rsp_fid_in;
      rsp_data_ff <= rsp_data_in;
      rsp_full_ff <= rsp_full_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_function_id = rsp_fid_ff;
   assign rsp_function_data = rsp_data_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_last = rsp_last_ff;

   `EMMT_ASSERT_IMPL(a_count_bound, clock, reset,
      1'b1, count_ff <= CNT_W'(MAX_ENTRIES),
      "entry count beyond table size")
   `EMMT_ASSERT_IMPL(a_hit_not_full, clock, reset,
      rsp_valid_ff && rsp_hit_ff, !rsp_full_ff,
      "hit result flagged as table full")
   `EMMT_ASSERT_IMPL(a_non_last_is_hit, clock, reset,
      rsp_valid_ff && !rsp_last_ff, rsp_hit_ff,
      "non-final result that is not a hit")

endmodule

`default_nettype wire

@@ src/event_mapping_match_table.sv @@
// Top level of the event mapping match table: joins the controller and the
// datapath. Depends on emmt_pkg, emmt_ctrl and emmt_datapath.
`default_nettype none

// An item is taken when start is high and busy is low. Results come out on
// the rsp_ ports for a single cycle each, flagged by rsp_strobe; there is no
// way to hold them off, so the receiver must take every strobed item as it
// comes. For clear and add the result appears the cycle after the item is
// taken and busy stays low, so another item may follow at once. A lookup
// walks the stored words one per cycle through the table memory's single
// registered read port and keeps busy high through the walk, drain and
// finish states (finish alone with an empty table), taking no new item.
// Matches are reported in table order, each held until the next matching
// word has been compared and strobed the cycle after; the final match, or
// a single miss, comes in the last busy cycle's successor with rsp_last
// set. Operation code three is taken and ignored.
// The table holds up to 64 words; a word added to a full table is dropped
// and its result carries rsp_table_full.
module event_mapping_match_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_loco_id,
   input  wire logic [1:0]  req_dot,
   input  wire logic [1:0]  req_direction,
   input  wire logic [31:0] req_entry_word,
   output logic             rsp_strobe,
   output logic             rsp_hit,
   output logic [5:0]       rsp_function_id,
   output logic [5:0]       rsp_function_data,
   output logic             rsp_table_full,
   output logic             rsp_last
);
   import emmt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequence each item: clear/add straight from idle, or walk the table
   emmt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   // hold the table and count, compare keys, register every result item
   emmt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_loco_id       (req_loco_id),
      .req_dot           (req_dot),
      .req_direction     (req_direction),
      .req_entry_word    (req_entry_word),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_function_id   (rsp_function_id),
      .rsp_function_data (rsp_function_data),
      .rsp_table_full    (rsp_table_full),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

@@ dv/emmt_checker.sv @@
`timescale 1ns / 1ps
// Checker for the event mapping match table: watches the command and result
// channels, predicts every result and compares it. Depends on emmt_pkg.
module emmt_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_loco_id,
   input  wire logic [1:0]  req_dot,
   input  wire logic [1:0]  req_direction,
   input  wire logic [31:0] req_entry_word,
   input  wire logic        rsp_strobe,
   input  wire logic        rsp_hit,
   input  wire logic [5:0]  rsp_function_id,
   input  wire logic [5:0]  rsp_function_data,
   input  wire logic        rsp_table_full,
   input  wire logic        rsp_last,
   output int               mismatch_count,
   output int               outstanding
);
   import emmt_pkg::*;

   typedef struct packed {
      logic              hit;
      logic [FID_W-1:0]  fid;
      logic [DATA_W-1:0] fdata;
      logic              table_full;
      logic              last;
   } match_result_type;

   logic [WORD_W-1:0] stored_words [MAX_ENTRIES];
   int                held_words = 0;
   match_result_type  expected_results [$];
   int                fail_total = 0;
   int                pending_depth = 0;

   assign mismatch_count = fail_total;
   assign outstanding = pending_depth;

   task automatic report_mismatch(input string what);
      fail_total++;
      if (fail_total <= 100) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // Walk the stored words as the block does; a lookup reports matches in
   // table order and marks only the final one as last.
   task automatic predict_results(input logic [1:0] op, input logic [15:0] id,
                                  input logic [1:0] dot, input logic [1:0] dir,
                                  input logic [31:0] word);
      match_result_type res;
      logic [KEY_W-1:0] key;
      int               hit_total;
      int               found;
      res = '0;
      res.last = 1'b1;
      key = {id, dot, dir};
      hit_total = 0;
      found = 0;
      case (op)
         OP_CLEAR: begin
            held_words = 0;
            expected_results.push_back(res);
         end
         OP_ADD: begin
            if (held_words >= MAX_ENTRIES) begin
               res.table_full = 1'b1;
            end else begin
               stored_words[held_words] = word;
               held_words++;
            end
            expected_results.push_back(res);
         end
         OP_EXEC: begin
            for (int i = 0; i < held_words; i++)
               if (stored_words[i][WORD_W-1 -: KEY_W] == key) hit_total++;
            if (hit_total == 0) begin
               expected_results.push_back(res);
            end else begin
               for (int i = 0; i < held_words; i++) begin
                  if (stored_words[i][WORD_W-1 -: KEY_W] == key) begin
                     found++;
                     res.hit = 1'b1;
                     res.fid = stored_words[i][DATA_W +: FID_W];
                     res.fdata = stored_words[i][DATA_W-1:0];
                     res.last = (found == hit_total);
                     expected_results.push_back(res);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         held_words = 0;
         expected_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result strobed with nothing expected");
            end else begin
               want = expected_results.pop_front();
               check_field("hit", rsp_hit, want.hit);
               check_field("fid", rsp_function_id, want.fid);
               check_field("fdata", rsp_function_data, want.fdata);
               check_field("table_full", rsp_table_full, want.table_full);
               check_field("last", rsp_last, want.last);
            end
         end
         if (start && !busy)
            predict_results(req_operation, req_loco_id, req_dot, req_direction,
                            req_entry_word);
      end
      pending_depth = expected_results.size();
   end

endmodule

@@ dv/tb_event_mapping_match_table.sv @@
`timescale 1ns / 1ps
// Testbench top for event_mapping_match_table: drives commands in bursts and
// gives the verdict. Depends on emmt_pkg, the block and dv/emmt_checker.sv.
module tb_event_mapping_match_table;
   import emmt_pkg::*;

   localparam int ITEM_TARGET = 480;
   // longest quiet spell: a full-table lookup with no strobe plus a long gap
   localparam int IDLE_LIMIT = 1000;
   // settle spell longer than a lookup on a full table holds busy
   localparam int SETTLE_CYCLES = 80;
   // the fourth operation code has no name in the package; the block drops it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_loco_id = '0;
   logic [1:0]  req_dot = '0;
   logic [1:0]  req_direction = '0;
   logic [31:0] req_entry_word = '0;
   logic        busy;
   logic        rsp_strobe;
   logic        rsp_hit;
   logic [5:0]  rsp_function_id;
   logic [5:0]  rsp_function_data;
   logic        rsp_table_full;
   logic        rsp_last;
   int          mismatch_count;
   int          outstanding;

   int               idle_cycles = 0;
   int               items_sent = 0;
   int               burst_left = 1;
   logic [KEY_W-1:0] key_pool [4];
   int               pool_size = 1;

   event_mapping_match_table dut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_operation,
      .req_loco_id,
      .req_dot,
      .req_direction,
      .req_entry_word,
      .rsp_strobe,
      .rsp_hit,
      .rsp_function_id,
      .rsp_function_data,
      .rsp_table_full,
      .rsp_last
   );

   emmt_checker match_checker (
      .clock,
      .reset,
      .start,
      .busy,
      .req_operation,
      .req_loco_id,
      .req_dot,
      .req_direction,
      .req_entry_word,
      .rsp_strobe,
      .rsp_hit,
      .rsp_function_id,
      .rsp_function_data,
      .rsp_table_full,
      .rsp_last,
      .mismatch_count,
      .outstanding
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: count cycles in which neither channel moves an item and end
   // the run if the block goes quiet for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Present one item and hold it until the block takes it. Busy is read
   // before the edge's updates land, so the edge that wakes us with busy low
   // is the one that accepts the item. At the end of a burst drop start,
   // scramble the idle fields and wait out a random gap; otherwise leave
   // start high so the next item follows back to back.
   task automatic send_item(input logic [1:0] op, input logic [15:0] id,
                            input logic [1:0] dot, input logic [1:0] dir,
                            input logic [31:0] word);
      req_operation <= op;
      req_loco_id <= id;
      req_dot <= dot;
      req_direction <= dir;
      req_entry_word <= word;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op != OP_UNUSED) items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         req_operation <= 2'($urandom);
         req_loco_id <= 16'($urandom);
         req_entry_word <= $urandom;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // mostly short bursts, now and then a long unbroken run
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 6);
      end
   endtask

   // Split a 20-bit key into its command fields; the entry word is a don't
   // care for a lookup, so fill it with noise.
   task automatic send_lookup(input logic [KEY_W-1:0] key);
      send_item(OP_EXEC, key[19:4], key[3:2], key[1:0], $urandom);
   endtask

   task automatic send_add(input logic [31:0] word);
      send_item(OP_ADD, 16'($urandom), 2'($urandom), 2'($urandom), word);
   endtask

   function automatic logic [KEY_W-1:0] pool_key();
      return key_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   // One well-formed session: clear, add words drawn mostly from a small key
   // pool so lookups find several matches, and look up along the way. A fill
   // session runs up to or past the table's capacity to provoke dropped adds.
   task automatic run_session(input bit fill, input int keys);
      int n_add;
      pool_size = keys;
      foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
      send_item(OP_CLEAR, 16'($urandom), 2'($urandom), 2'($urandom), $urandom);
      n_add = fill ? $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 6) : $urandom_range(0, 12);
      repeat (n_add) begin
         if ($urandom_range(0, 9) == 0) send_add($urandom);
         else send_add({pool_key(), 12'($urandom)});
         if ($urandom_range(0, 3) == 0) send_lookup(pool_key());
      end
      repeat ($urandom_range(2, 5)) begin
         if ($urandom_range(0, 9) == 0)
            send_item(OP_UNUSED, 16'($urandom), 2'($urandom), 2'($urandom), $urandom);
         if ($urandom_range(0, 3) == 0) send_lookup(KEY_W'($urandom));
         else send_lookup(pool_key());
      end
   endtask

   initial begin
      int kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: lookup on an empty table, the ignored code, extreme words
      // and keys, repeated keys, clear and reuse of the first slot.
      send_lookup(20'h00000);
      send_item(OP_UNUSED, 16'hFFFF, 2'd3, 2'd3, 32'hFFFF_FFFF);
      send_add(32'h0000_0000);
      send_add(32'hFFFF_FFFF);
      send_add({20'hFFFFF, 6'h15, 6'h2A});
      send_add({20'h00000, 6'h3F, 6'h00});
      send_add({20'h12345, 6'h2A, 6'h15});
      send_lookup(20'h00000);
      send_lookup(20'hFFFFF);
      send_lookup(20'h12345);
      send_lookup(20'h12346);
      send_item(OP_UNUSED, 16'h0000, 2'd0, 2'd0, 32'h0000_0000);
      send_lookup(20'h00000);
      send_item(OP_CLEAR, 16'hFFFF, 2'd3, 2'd3, 32'hFFFF_FFFF);
      send_lookup(20'hFFFFF);
      send_add({20'hA5A5A, 6'h01, 6'h3E});
      send_lookup(20'hA5A5A);
      send_item(OP_CLEAR, 16'h0000, 2'd0, 2'd0, 32'h0000_0000);
      send_lookup(20'hA5A5A);

      // Fill the table mostly with one key so a lookup returns most slots, and
      // push adds up to or past the end to see extras dropped.
      run_session(1'b1, 1);

      // Random sessions, with the odd burst of unstructured noise.
      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(5, 15))
               send_item(2'($urandom), 16'($urandom), 2'($urandom), 2'($urandom),
                         $urandom);
         end else begin
            run_session(kind == 1, $urandom_range(1, 4));
         end
      end

      // Drop start, let the outstanding results drain, then allow a lookup's
      // worth of cycles for anything stray.
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
